@@ hw/rtl/ths_pkg.sv @@
// Package for the tagged handle set with swap-on-remove.
// Holds sizes, status and action codes, register indexes and the control state type.
// Used by tagged_handle_set_swap_remove; depends on nothing.
package ths_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 6;
    localparam int HANDLE_W    = 16;
    localparam int FLAG_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int ENTRY_W     = HANDLE_W + 2 * BYTE_W;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(32);
    localparam logic [CNT_W-1:0] MAX_COUNT      = CNT_W'(MAX_ENTRIES);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE
    } state_t;

endpackage

@@ hw/rtl/tagged_handle_set_swap_remove.sv @@
// Top level of the bounded handle set with swap-on-remove and two flag bytes per entry.
// Depends on ths_pkg and on ths_ram, which holds the entries.
//
// Channel   Direction  Signals                            Transfer when
// command   in         start, action, handle, flag_word   start high and busy low
// result    out        done, status, occupancy            done high, one cycle
// config    in/out     APB: psel ... pready               psel, penable, pwrite high
//
// An insert leaves busy low, so inserts can follow back to back.
// A remove scans one stored entry per cycle through the single RAM read port;
// on a match the last entry is moved into the matched slot; done is registered.
// Reset clears the count and sets the capacity to 32; the RAM contents are not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
module tagged_handle_set_swap_remove
    import ths_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [HANDLE_W-1:0]   handle,
    input  logic [FLAG_W-1:0]     flag_word,
    output logic                  done,
    output logic [1:0]            status,
    output logic [CNT_W-1:0]      occupancy,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    capacity_reg;
    logic [HANDLE_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [CNT_W-1:0]    occupancy_reg;

    logic                accept;
    logic                cfg_write;
    logic [CNT_W-1:0]    limit;
    logic                full;
    logic [IDX_W-1:0]    last_idx;
    logic                match;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign limit     = (capacity_reg < MAX_COUNT) ? capacity_reg : MAX_COUNT;
    assign full      = (count_reg >= limit) || (count_reg >= MAX_COUNT);
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign match     = cmp_valid_reg && (rd_data[ENTRY_W-1 -: HANDLE_W] == key_reg);

    ths_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_REMOVE) && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = ST_MOVE;
                end
                else if (cmp_valid_reg && (cmp_idx_reg == last_idx))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOVE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        key_next       = key_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_data        = {handle, flag_word[FLAG_W-1 -: BYTE_W], flag_word[BYTE_W-1:0]};
        rd_en          = 1'b0;
        rd_addr        = scan_idx_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next       = handle;
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                    if (action == ACT_INSERT)
                    begin
                        done_next = 1'b1;
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            status_next = STATUS_DONE;
                            wr_en       = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_NOT_FOUND;
                    end
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    rd_en   = 1'b1;
                    rd_addr = last_idx;
                end
                else if (cmp_valid_reg && (cmp_idx_reg == last_idx))
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_NOT_FOUND;
                end
                else
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
            end
            ST_MOVE:
            begin
                wr_en       = 1'b1;
                wr_addr     = cmp_idx_reg;
                wr_data     = rd_data;
                count_next  = count_reg - CNT_W'(1);
                done_next   = 1'b1;
                status_next = STATUS_DONE;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            capacity_reg  <= CAPACITY_RESET;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
            if (cfg_write && (paddr[APB_ADDR_W-1] == REG_CAPACITY))
            begin
                capacity_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        scan_idx_reg  <= scan_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        status_reg    <= status_next;
        occupancy_reg <= count_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[APB_ADDR_W-1] == REG_CAPACITY)
                       ? {{(APB_DATA_W - CNT_W){1'b0}}, capacity_reg}
                       : '0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("Entry count exceeds the storage size.");

    a_move_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MOVE |=> state_reg == ST_IDLE && done_reg)
        else $error("Swap step did not finish with a result.");

    a_move_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MOVE |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("Remove did not decrement the count.");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && cmp_valid_reg |-> CNT_W'(cmp_idx_reg) < count_reg)
        else $error("Scan compared an unoccupied slot.");

    a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != STATUS_DONE |-> count_reg == $past(count_reg))
        else $error("Refused transfer changed the count.");
`endif

endmodule

@@ hw/rtl/ths_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for the entry store of the handle set; depends on nothing.
module ths_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
